@@ rtl/dual_running_interval_mean_assert.svh @@
// Assertion macros shared by the checkers of this block.
// Each macro samples on the rising edge of clock; the gated forms are off during reset.
`ifndef DUAL_RUNNING_INTERVAL_MEAN_ASSERT_SVH
`define DUAL_RUNNING_INTERVAL_MEAN_ASSERT_SVH

`define DRIM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("drim: next-cycle check failed");

`define DRIM_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("drim: same-cycle check failed");

`define DRIM_ASSERT_RESET(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("drim: reset check failed");

`endif

@@ rtl/drim_pkg.sv @@
package drim_pkg;

   localparam int TIME_BITS  = 64;
   localparam int COUNT_BITS = 32;
   localparam int FIELD_BITS = 64;
   localparam int ITER_BITS  = $clog2(TIME_BITS);

   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [FIELD_BITS-1:0] field_type;

   typedef struct packed {
      logic start;
      logic clear;
      logic take;
   } lane_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } lane_stat_type;

   // Sign-extend a lane value to the width of the channel fields.
   function automatic field_type widen(input time_type v);
      return FIELD_BITS'($signed(v));
   endfunction

endpackage

@@ rtl/drim_req_if.sv @@
interface drim_req_if;
   import drim_pkg::*;

   logic      valid;
   logic      ready;
   logic      has_push_time;
   field_type push_time;
   field_type time_stamp;

   modport source (output valid, output has_push_time, output push_time,
                   output time_stamp, input ready);
   modport sink   (input valid, input has_push_time, input push_time,
                   input time_stamp, output ready);
endinterface

@@ rtl/drim_rsp_if.sv @@
interface drim_rsp_if;
   import drim_pkg::*;

   logic      valid;
   logic      ready;
   field_type push_gap;
   field_type push_gap_mean;
   field_type stamp_gap;
   field_type stamp_gap_mean;

   modport source (output valid, output push_gap, output push_gap_mean,
                   output stamp_gap, output stamp_gap_mean, input ready);
   modport sink   (input valid, input push_gap, input push_gap_mean,
                   input stamp_gap, input stamp_gap_mean, output ready);
endinterface

@@ rtl/drim_lane.sv @@
module drim_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  drim_pkg::lane_ctl_type ctl,
   input  drim_pkg::time_type     value,
   output drim_pkg::lane_stat_type stat,
   output drim_pkg::time_type     gap,
   output drim_pkg::time_type     mean
);
   import drim_pkg::*;

   typedef enum logic [2:0] {IDLE, SETUP, DIVIDE, SIGN, DONE} state_type;

   state_type            state_ff;
   time_type             prev_ff;
   time_type             sum_ff;
   time_type             mean_ff;
   time_type             gap_ff;
   time_type             quo_ff;
   count_type            count_ff;
   count_type            rem_ff;
   logic                 neg_ff;
   logic [ITER_BITS-1:0] iter_ff;

   time_type        gap_in;
   logic [COUNT_BITS:0] trial;
   logic            fits;

   assign gap_in = value - prev_ff;
   // One restoring step: bring down the next dividend bit and try the count.
   assign trial  = {rem_ff, quo_ff[TIME_BITS-1]};
   assign fits   = trial >= {1'b0, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         prev_ff  <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
         mean_ff  <= '0;
      end else begin
         case (state_ff)
            IDLE: begin
               if (ctl.start) begin
                  if (ctl.clear) begin
                     prev_ff  <= '0;
                     sum_ff   <= '0;
                     count_ff <= '0;
                     mean_ff  <= '0;
                     gap_ff   <= '0;
                     state_ff <= DONE;
                  end else begin
                     gap_ff  <= gap_in;
                     prev_ff <= value;
                     // A remembered value of zero marks the first sample of a run.
                     if (prev_ff == '0) begin
                        state_ff <= DONE;
                     end else begin
                        if (count_ff != '1) begin
                           count_ff <= count_ff + 1'b1;
                        end
                        sum_ff   <= sum_ff + gap_in;
                        state_ff <= SETUP;
                     end
                  end
               end
            end
            SETUP: begin
               neg_ff   <= sum_ff[TIME_BITS-1];
               quo_ff   <= sum_ff[TIME_BITS-1] ? ('0 - sum_ff) : sum_ff;
               rem_ff   <= '0;
               iter_ff  <= ITER_BITS'(TIME_BITS - 1);
               state_ff <= DIVIDE;
            end
            DIVIDE: begin
               rem_ff <= fits ? COUNT_BITS'(trial - {1'b0, count_ff})
                              : trial[COUNT_BITS-1:0];
               quo_ff <= {quo_ff[TIME_BITS-2:0], fits};
               if (iter_ff == '0) begin
                  state_ff <= SIGN;
               end else begin
                  iter_ff <= iter_ff - 1'b1;
               end
            end
            SIGN: begin
               mean_ff  <= neg_ff ? ('0 - quo_ff) : quo_ff;
               state_ff <= DONE;
            end
            DONE: begin
               if (ctl.take) begin
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign stat.idle = (state_ff == IDLE);
   assign stat.done = (state_ff == DONE);
   assign gap       = gap_ff;
   assign mean      = mean_ff;

endmodule

@@ rtl/drim_merge.sv @@
module drim_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  drim_pkg::lane_stat_type push_stat,
   input  drim_pkg::lane_stat_type stamp_stat,
   input  drim_pkg::time_type      push_gap,
   input  drim_pkg::time_type      push_mean,
   input  drim_pkg::time_type      stamp_gap,
   input  drim_pkg::time_type      stamp_mean,
   output logic                    take,
   drim_rsp_if.source              rsp_bus
);
   import drim_pkg::*;

   logic      rsp_valid_ff;
   field_type push_gap_ff;
   field_type push_mean_ff;
   field_type stamp_gap_ff;
   field_type stamp_mean_ff;

   // Both lanes must have finished, and the output register must be free or emptying.
   assign take = push_stat.done && stamp_stat.done && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         push_gap_ff   <= widen(push_gap);
         push_mean_ff  <= widen(push_mean);
         stamp_gap_ff  <= widen(stamp_gap);
         stamp_mean_ff <= widen(stamp_mean);
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.push_gap       = push_gap_ff;
   assign rsp_bus.push_gap_mean  = push_mean_ff;
   assign rsp_bus.stamp_gap      = stamp_gap_ff;
   assign rsp_bus.stamp_gap_mean = stamp_mean_ff;

endmodule

@@ rtl/dual_running_interval_mean.sv @@
// Channel   Direction  Modport  Item contents
// req_bus   in         sink     has_push_time, push_time, time_stamp
// rsp_bus   out        source   push_gap, push_gap_mean, stamp_gap, stamp_gap_mean
//
// An item that updates a mean passes through SETUP, DIVIDE and SIGN in each lane
// before it reaches rsp_bus.valid; the restoring divider yields one quotient bit per cycle.
// A clear item or a first sample skips the divider. One item is in flight at a time.
// Reset is synchronous; it zeroes each lane's sum, count, mean and last value, not its gap.
// A stalled result sits in the output register; the next item is taken meanwhile.
module dual_running_interval_mean (
   input  logic     clock,
   input  logic     reset,
   drim_req_if.sink   req_bus,
   drim_rsp_if.source rsp_bus
);
   import drim_pkg::*;

   lane_ctl_type  lane_ctl;
   lane_stat_type push_stat;
   lane_stat_type stamp_stat;
   time_type      push_gap;
   time_type      push_mean;
   time_type      stamp_gap;
   time_type      stamp_mean;
   logic          take;

   assign req_bus.ready  = push_stat.idle && stamp_stat.idle;
   assign lane_ctl.start = req_bus.valid && req_bus.ready;
   assign lane_ctl.clear = !req_bus.has_push_time;
   assign lane_ctl.take  = take;

   drim_lane u_push_lane (
      .clock (clock),
      .reset (reset),
      .ctl   (lane_ctl),
      .value (req_bus.push_time[TIME_BITS-1:0]),
      .stat  (push_stat),
      .gap   (push_gap),
      .mean  (push_mean)
   );

   drim_lane u_stamp_lane (
      .clock (clock),
      .reset (reset),
      .ctl   (lane_ctl),
      .value (req_bus.time_stamp[TIME_BITS-1:0]),
      .stat  (stamp_stat),
      .gap   (stamp_gap),
      .mean  (stamp_mean)
   );

   drim_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push_stat  (push_stat),
      .stamp_stat (stamp_stat),
      .push_gap   (push_gap),
      .push_mean  (push_mean),
      .stamp_gap  (stamp_gap),
      .stamp_mean (stamp_mean),
      .take       (take),
      .rsp_bus    (rsp_bus)
   );

endmodule

@@ rtl/drim_check.sv @@
`include "dual_running_interval_mean_assert.svh"

module drim_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // A result stays offered until it is taken.
   `DRIM_ASSERT_NEXT(rsp_hold_a, rsp_valid && !rsp_ready, rsp_valid)

   // Only one item is in flight: an accept closes the input side.
   `DRIM_ASSERT_NEXT(one_in_flight_a, req_valid && req_ready, !req_ready)

   // A new result only appears for an item that was being worked on.
   `DRIM_ASSERT_NOW(rsp_from_item_a, $rose(rsp_valid), $past(!req_ready))

   // Reset empties the output register.
   `DRIM_ASSERT_RESET(reset_empty_a, reset, !rsp_valid)

endmodule

bind dual_running_interval_mean drim_check u_drim_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready)
);
